// File: rtl/core/ael_pkg.sv
package ael_pkg;

  localparam int CordicStepsDef = 24;
  localparam int CfgAw = 3;
  localparam int CfgDw = 24;
  localparam int DW = 36;

  localparam logic [CfgAw-1:0] RegOriginX = 3'd0;
  localparam logic [CfgAw-1:0] RegOriginY = 3'd1;
  localparam logic [CfgAw-1:0] RegOriginZ = 3'd2;
  localparam logic [CfgAw-1:0] RegProjRad = 3'd3;
  localparam logic [CfgAw-1:0] RegBoxW    = 3'd4;
  localparam logic [CfgAw-1:0] RegBoxH    = 3'd5;
  localparam logic [CfgAw-1:0] RegMirX    = 3'd6;
  localparam logic [CfgAw-1:0] RegMirY    = 3'd7;

  localparam logic [23:0] ProjRadRst = 24'd1310720;
  localparam logic [23:0] BoxRst     = 24'd327680;
  localparam logic [31:0] InvGain    = 32'd2608131496;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/azimuthal_equidistant_layout.sv
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_valid / in_ready    | in_pos_x/y/z, in_last_point
// out_    | out | out_valid / out_ready  | out_x, out_y, out_last_result, out_degenerate
// cfg_    | in  | cfg_we                 | cfg_index, cfg_data
//
// A pole point skips the CORDIC passes and goes from setup straight to the result; a new
// transaction is accepted only after the previous result is taken. One shared CORDIC
// add/shift step runs three passes; an 18x32 multiplier on both magnitude halves removes
// the gain, a 24x32 product scales theta. in_ready is high only in idle with the output
// register empty; out_ready stalls hold the result. Reset (rst_n low, synchronous)
// restores defaults, starts a new set.
module azimuthal_equidistant_layout #(
  parameter int CORDIC_STEPS = ael_pkg::CordicStepsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          in_pos_x,
  input  logic signed [23:0]          in_pos_y,
  input  logic signed [23:0]          in_pos_z,
  input  logic                        in_last_point,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y,
  output logic                        out_last_result,
  output logic                        out_degenerate,
  input  logic                        cfg_we,
  input  logic [ael_pkg::CfgAw-1:0]   cfg_index,
  input  logic [ael_pkg::CfgDw-1:0]   cfg_data
);

  localparam int DW = ael_pkg::DW;
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_CORD  = 4'd2;
  localparam logic [3:0] S_MLO   = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_GSUM  = 4'd5;
  localparam logic [3:0] S_RAD   = 4'd6;
  localparam logic [3:0] S_RSUM  = 4'd7;
  localparam logic [3:0] S_ROUND = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  // pass: 0 azimuth, 1 polar, 2 rotation
  localparam logic [1:0] P_AZ  = 2'd0;
  localparam logic [1:0] P_POL = 2'd1;
  localparam logic [1:0] P_ROT = 2'd2;

  logic signed [23:0] org_x_r, org_y_r, org_z_r;
  logic [23:0]        prad_r, bw_r, bh_r;
  logic               mir_x_r, mir_y_r;

  logic [3:0]  st_r, st_nxt;
  logic [1:0]  pass_r;
  logic [IW-1:0] it_r;
  logic        gsel_r;            // gain pass: 0 x, 1 y (rotation only)
  logic signed [DW-1:0] cx_r, cy_r, dz_r;
  logic signed [32:0]   cz_r;
  logic [31:0] phi_r;
  logic        neg_r, pole_r, last_r;
  logic [DW-1:0] mag_r;
  logic        msign_r;
  logic [49:0] plo_r;
  logic [67:0] acc_r;
  logic signed [DW-1:0] gx_r;
  logic signed [31:0] xp_r, yp_r;
  logic signed [31:0] mnx_r, mxx_r, mny_r, mxy_r;
  logic        first_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      prad_r <= ael_pkg::ProjRadRst;
      bw_r <= ael_pkg::BoxRst; bh_r <= ael_pkg::BoxRst;
      mir_x_r <= 1'b0; mir_y_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ael_pkg::RegOriginX: org_x_r <= cfg_data;
        ael_pkg::RegOriginY: org_y_r <= cfg_data;
        ael_pkg::RegOriginZ: org_z_r <= cfg_data;
        ael_pkg::RegProjRad: prad_r <= cfg_data;
        ael_pkg::RegBoxW:    bw_r <= cfg_data;
        ael_pkg::RegBoxH:    bh_r <= cfg_data;
        ael_pkg::RegMirX:    mir_x_r <= cfg_data[0];
        ael_pkg::RegMirY:    mir_y_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid;
  wire in_fire = in_valid && in_ready;

  // shared CORDIC step
  logic signed [DW-1:0] xs, ys;
  logic [31:0] at;
  logic dir_pos;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign at = ael_pkg::atan_lut(5'(it_r));
  assign dir_pos = (pass_r == P_ROT) ? !cz_r[32] : !cy_r[DW-1];
  wire last_it = (it_r == IW'(CORDIC_STEPS - 1));

  // dir_pos: vectoring y >= 0, rotation z >= 0
  logic signed [DW-1:0] cx_step, cy_step;
  logic signed [32:0]   cz_step;
  always_comb begin
    if (dir_pos) begin
      cx_step = cx_r + ((pass_r == P_ROT) ? -ys : ys);
      cy_step = cy_r + ((pass_r == P_ROT) ? xs : -xs);
      cz_step = (pass_r == P_ROT) ? cz_r - $signed({1'b0, at})
                                  : cz_r + $signed({1'b0, at});
    end else begin
      cx_step = cx_r + ((pass_r == P_ROT) ? ys : -ys);
      cy_step = cy_r + ((pass_r == P_ROT) ? -xs : xs);
      cz_step = (pass_r == P_ROT) ? cz_r + $signed({1'b0, at})
                                  : cz_r - $signed({1'b0, at});
    end
  end

  // shared 18x32 partial product of the 36-bit magnitude
  logic [17:0] mhalf;
  logic [49:0] prod;
  assign mhalf = (st_r == S_MLO) ? mag_r[17:0] : mag_r[35:18];
  assign prod = mhalf * ael_pkg::InvGain;

  // gain-removed result, rounded half away from zero
  logic [35:0] gmag;
  logic signed [DW-1:0] gres;
  assign gmag = 36'((acc_r + 68'h80000000) >> 32);
  assign gres = msign_r ? -$signed(gmag) : $signed(gmag);

  // polar angle clamp
  logic [31:0] th;
  logic [31:0] thc;
  assign th = cz_r[31:0];
  assign thc = (th >= 32'hC0000000) ? 32'd0 : ((th > 32'h80000000) ? 32'h80000000 : th);

  // rotation angle fold
  logic signed [32:0] zs;
  assign zs = $signed({phi_r[31], phi_r});

  logic signed [DW-1:0] xr, yr;
  assign xr = neg_r ? -gx_r : gx_r;
  assign yr = neg_r ? -gres : gres;
  logic signed [31:0] xpn, ypn;
  assign xpn = 32'((xr + 36'sd32) >>> 6);
  assign ypn = 32'((yr + 36'sd32) >>> 6);

  logic signed [33:0] ox, oy;
  assign ox = ($signed({xp_r[31], xp_r, 1'b0}) - $signed({10'd0, bw_r})) >>> 1;
  assign oy = ($signed({yp_r[31], yp_r, 1'b0}) - $signed({10'd0, bh_r})) >>> 1;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_fire) st_nxt = S_PRE;
      S_PRE:   st_nxt = pole_r ? S_FIN : S_CORD;
      S_CORD:  if (last_it) st_nxt = S_MLO;
      S_MLO:   st_nxt = S_MHI;
      S_MHI:   st_nxt = S_GSUM;
      S_GSUM:  st_nxt = (pass_r == P_POL) ? S_RAD :
                        ((pass_r == P_ROT) && gsel_r) ? S_ROUND :
                        (pass_r == P_ROT) ? S_MLO : S_CORD;
      S_RAD:   st_nxt = S_RSUM;
      S_RSUM:  st_nxt = S_CORD;
      S_ROUND: st_nxt = S_FIN;
      S_FIN:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      first_r <= 1'b1;
      mnx_r <= '0; mxx_r <= '0; mny_r <= '0; mxy_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_fire) begin
          cx_r <= DW'(($signed({org_x_r[23], org_x_r}) - in_pos_x)) <<< 6;
          cy_r <= DW'(($signed({org_y_r[23], org_y_r}) - in_pos_y)) <<< 6;
          dz_r <= DW'(($signed({org_z_r[23], org_z_r}) - in_pos_z)) <<< 6;
          last_r <= in_last_point;
          pole_r <= (org_x_r == in_pos_x) && (org_y_r == in_pos_y);
          pass_r <= P_AZ;
        end
        S_PRE: begin
          xp_r <= '0; yp_r <= '0;
          it_r <= '0; gsel_r <= 1'b0;
          if (cx_r[DW-1]) begin
            cx_r <= -cx_r; cy_r <= -cy_r; cz_r <= 33'h080000000;
          end else cz_r <= '0;
        end
        S_CORD: begin
          cx_r <= cx_step; cy_r <= cy_step; cz_r <= cz_step;
          it_r <= it_r + 1'b1;
          // take the magnitude from x after the final step
          if (last_it) begin
            mag_r <= cx_step[DW-1] ? -cx_step : cx_step;
            msign_r <= cx_step[DW-1];
          end
        end
        S_MLO: begin
          plo_r <= prod;
        end
        S_MHI: acc_r <= {prod, 18'd0} + {18'd0, plo_r};
        S_GSUM: begin
          it_r <= '0;
          unique case (pass_r)
            P_AZ: begin
              phi_r <= cz_r[31:0];
              // polar pass: atan2(rxy, dz)
              if (dz_r[DW-1]) begin
                cx_r <= -dz_r; cy_r <= -gres; cz_r <= 33'h080000000;
              end else begin
                cx_r <= dz_r; cy_r <= gres; cz_r <= '0;
              end
              pass_r <= P_POL;
            end
            P_POL: acc_r <= 68'(prad_r * thc);
            default: begin
              if (!gsel_r) begin
                gx_r <= gres; gsel_r <= 1'b1;
              end
            end
          endcase
        end
        S_RAD: acc_r <= (acc_r + 68'd8388608) >> 24;
        S_RSUM: begin
          cx_r <= DW'(acc_r); cy_r <= '0;
          pass_r <= P_ROT;
          if (zs > 33'sh040000000) begin
            cz_r <= zs - 33'sh080000000; neg_r <= 1'b1;
          end else if (zs < -33'sh040000000) begin
            cz_r <= zs + 33'sh080000000; neg_r <= 1'b1;
          end else begin
            cz_r <= zs; neg_r <= 1'b0;
          end
        end
        S_ROUND: begin
          xp_r <= xpn; yp_r <= ypn;
        end
        S_FIN: begin
          if (first_r) begin
            mnx_r <= xp_r; mxx_r <= xp_r; mny_r <= yp_r; mxy_r <= yp_r;
          end else begin
            if (xp_r > mxx_r) mxx_r <= xp_r;
            if (xp_r < mnx_r) mnx_r <= xp_r;
            if (yp_r > mxy_r) mxy_r <= yp_r;
            if (yp_r < mny_r) mny_r <= yp_r;
          end
          first_r <= last_r;
          out_valid <= 1'b1;
          out_x <= 32'(mir_x_r ? -ox : ox);
          out_y <= 32'(mir_y_r ? -oy : oy);
          out_last_result <= last_r;
          out_degenerate <= last_r && (first_r ||
            (((xp_r < mnx_r) ? xp_r : mnx_r) == ((xp_r > mxx_r) ? xp_r : mxx_r)) ||
            (((yp_r < mny_r) ? yp_r : mny_r) == ((yp_r > mxy_r) ? yp_r : mxy_r)));
        end
        default: ;
      endcase
      // second gain pass of the rotation works on y
      if (st_r == S_GSUM && pass_r == P_ROT && !gsel_r) begin
        mag_r <= cy_r[DW-1] ? -cy_r : cy_r;
        msign_r <= cy_r[DW-1];
      end
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == S_FIN) else $error("result out of sequence");
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CORD) |-> (pass_r != 2'd3)) else $error("bad pass");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int Steps = ael_pkg::CordicStepsDef;
  localparam int LatencyPad = 3 * ael_pkg::CordicStepsDef + 60;
  localparam longint CycleLimit = 2_000_000;

  // Binary-angle arctangent table, one full turn = 2^32
  localparam bit [31:0] AtanStep [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct {
    logic signed [23:0] px, py, pz;
    logic               last;
  } sensor_pos_t;

  typedef struct {
    logic signed [31:0] x, y;
    logic               last, degen;
  } layout_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y;
  logic out_last_result, out_degenerate;
  logic cfg_we = 1'b0;
  logic [ael_pkg::CfgAw-1:0] cfg_index = '0;
  logic [ael_pkg::CfgDw-1:0] cfg_data = '0;

  azimuthal_equidistant_layout DUT (.*);

  always #2 clk = ~clk;

  // Local copy of the register file and the running bounds
  longint org_x, org_y, org_z, prad, box_w, box_h;
  bit mir_x, mir_y;
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  bit new_set;

  sensor_pos_t pos_queue[$];
  layout_pt_t  pending_layout[$];
  int errors = 0;
  int results_seen = 0;
  int degen_seen = 0;
  int sets_sent = 0;
  longint cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch %0d at %0t: %s", errors, $realtime, what);
  endtask

  function automatic longint drop_gain(input longint v);
    bit [63:0] mag, r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    r = (mag * 64'd2608131496 + 64'd2147483648) >> 32;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Vectoring pass: angle of (x, y) and its gain-corrected length
  function automatic bit [31:0] vec_angle(input longint x, input longint y,
                                          output longint len);
    bit [31:0] ang;
    longint xs, ys;
    ang = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang = ang + AtanStep[i];
      end else begin
        x = x - ys; y = y + xs; ang = ang - AtanStep[i];
      end
    end
    len = drop_gain(x);
    return ang;
  endfunction

  // Rotation pass: turn (m, 0) by binary angle a
  function automatic void rotate_len(input longint m, input bit [31:0] a,
                                     output longint cx, output longint cy);
    longint z, x, y, xs, ys;
    bit flip;
    z = (a < 32'h8000_0000) ? longint'(a) : longint'(a) - 64'sd4294967296;
    x = m;
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= longint'(AtanStep[i]);
      end else begin
        x = x + ys; y = y - xs; z += longint'(AtanStep[i]);
      end
    end
    x = drop_gain(x);
    y = drop_gain(y);
    cx = flip ? -x : x;
    cy = flip ? -y : y;
  endfunction

  // Project one sensor position and advance the set bounds
  function automatic layout_pt_t project_point(input sensor_pos_t p);
    layout_pt_t r;
    longint dx, dy, dz, xp, yp, rxy, rr, theta, cx, cy, ox, oy;
    bit [31:0] phi, th;
    bit [63:0] m;
    logic signed [31:0] qx, qy;
    dx = (org_x - longint'(p.px)) * 64;
    dy = (org_y - longint'(p.py)) * 64;
    dz = (org_z - longint'(p.pz)) * 64;
    xp = 0;
    yp = 0;
    if (dx != 0 || dy != 0) begin
      phi = vec_angle(dx, dy, rxy);
      th = vec_angle(dz, rxy, rr);
      theta = (th >= 32'hC000_0000) ? longint'(th) - 64'sd4294967296 : longint'(th);
      if (theta < 0) theta = 0;
      if (theta > 64'sd2147483648) theta = 64'sd2147483648;
      m = (64'(prad) * 64'(theta) + 64'd8388608) >> 24;
      rotate_len(longint'(m), phi, cx, cy);
      xp = (cx + 32) >>> 6;
      yp = (cy + 32) >>> 6;
    end
    qx = xp[31:0];
    qy = yp[31:0];
    if (new_set) begin
      lo_x = qx; hi_x = qx; lo_y = qy; hi_y = qy;
      new_set = 0;
    end else begin
      if (qx > hi_x) hi_x = qx;
      if (qx < lo_x) lo_x = qx;
      if (qy > hi_y) hi_y = qy;
      if (qy < lo_y) lo_y = qy;
    end
    r.degen = 0;
    if (p.last) begin
      r.degen = (lo_x == hi_x) || (lo_y == hi_y);
      new_set = 1;
    end
    ox = (2 * xp - box_w) >>> 1;
    oy = (2 * yp - box_h) >>> 1;
    if (mir_x) ox = -ox;
    if (mir_y) oy = -oy;
    r.x = ox[31:0];
    r.y = oy[31:0];
    r.last = p.last;
    return r;
  endfunction

  // Driver: present queued positions, random gaps with calm stretches
  int in_gap = 0;
  bit in_calm = 0;
  always @(posedge clk) begin
    bit v;
    sensor_pos_t p;
    sensor_pos_t got;
    v = in_valid;
    if (!rst_n) begin
      v = 0;
    end else begin
      if (in_valid && in_ready) begin
        got = '{in_pos_x, in_pos_y, in_pos_z, in_last_point};
        pending_layout.insert(pending_layout.size(), project_point(got));
        v = 0;
        if ($urandom_range(0, 19) == 0) in_calm = ~in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 10);
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pos_queue.size() > 0) begin
          p = pos_queue.pop_front();
          v = 1;
          in_pos_x <= p.px;
          in_pos_y <= p.py;
          in_pos_z <= p.pz;
          in_last_point <= p.last;
        end
      end
    end
    in_valid <= v;
  end

  // Monitor: stall the result side at random, check each transaction
  int out_gap = 0;
  bit out_calm = 0;
  always @(posedge clk) begin
    layout_pt_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_layout.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = pending_layout.pop_front();
        if (out_x !== e.x) report($sformatf("x got %0d want %0d", out_x, e.x));
        if (out_y !== e.y) report($sformatf("y got %0d want %0d", out_y, e.y));
        if (out_last_result !== e.last)
          report($sformatf("last got %b want %b", out_last_result, e.last));
        if (out_degenerate !== e.degen)
          report($sformatf("degenerate got %b want %b", out_degenerate, e.degen));
        if (e.degen) degen_seen++;
      end
      if ($urandom_range(0, 19) == 0) out_calm = ~out_calm;
      out_gap = out_calm ? 0 : $urandom_range(0, 10);
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input logic [ael_pkg::CfgAw-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    case (idx)
      ael_pkg::RegOriginX: org_x = longint'($signed(val[23:0]));
      ael_pkg::RegOriginY: org_y = longint'($signed(val[23:0]));
      ael_pkg::RegOriginZ: org_z = longint'($signed(val[23:0]));
      ael_pkg::RegProjRad: prad = longint'(val[23:0]);
      ael_pkg::RegBoxW:    box_w = longint'(val[23:0]);
      ael_pkg::RegBoxH:    box_h = longint'(val[23:0]);
      ael_pkg::RegMirX:    mir_x = val[0];
      ael_pkg::RegMirY:    mir_y = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued position is out and its result checked
  task automatic drain();
    do @(negedge clk);
    while (pos_queue.size() != 0 || in_valid || pending_layout.size() != 0);
    repeat (LatencyPad) @(posedge clk);
  endtask

  function automatic void add_pos(input longint x, input longint y, input longint z,
                                  input bit last);
    sensor_pos_t p;
    p = '{24'(x), 24'(y), 24'(z), last};
    pos_queue.insert(pos_queue.size(), p);
    if (last) sets_sent++;
  endfunction

  // One well-formed set of random length with a mix of point kinds
  task automatic random_set();
    int n, kind;
    longint x, y, z;
    n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
    x = 0; y = 0; z = 0;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        x = $signed(24'($urandom)); y = $signed(24'($urandom));
        z = $signed(24'($urandom));
      end else if (kind <= 5) begin
        x = org_x + $signed(12'($urandom)); y = org_y + $signed(12'($urandom));
        z = org_z + $signed(16'($urandom));
      end else if (kind == 6) begin
        // pole: no horizontal offset from the origin
        x = org_x; y = org_y; z = $signed(24'($urandom));
      end else if (kind == 7) begin
        // repeat the previous point
      end else if (kind == 8) begin
        x = org_x + $urandom_range(0, 1) - 1; y = org_y;
        z = $signed(24'($urandom));
      end else begin
        x = $urandom_range(0, 1) ? 8388607 : -8388608;
        y = $urandom_range(0, 1) ? 8388607 : -8388608;
        z = $urandom_range(0, 1) ? 8388607 : -8388608;
      end
      if (x > 8388607) x = 8388607;
      if (x < -8388608) x = -8388608;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      if (z > 8388607) z = 8388607;
      if (z < -8388608) z = -8388608;
      add_pos(x, y, z, i == n - 1);
    end
  endtask

  initial begin
    int phase_items;
    org_x = 0; org_y = 0; org_z = 0;
    prad = ael_pkg::ProjRadRst; box_w = ael_pkg::BoxRst; box_h = ael_pkg::BoxRst;
    mir_x = 0; mir_y = 0;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    new_set = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: pole, axes, extremes, lone points
    add_pos(0, 0, 0, 1);
    add_pos(0, 0, 8388607, 1);
    add_pos(0, 0, -8388608, 0);
    add_pos(1, 0, 0, 0);
    add_pos(-1, 0, 0, 0);
    add_pos(0, 1, 0, 0);
    add_pos(0, -1, 0, 1);
    add_pos(8388607, 8388607, 8388607, 0);
    add_pos(-8388608, -8388608, -8388608, 0);
    add_pos(8388607, -8388608, 0, 0);
    add_pos(-8388608, 8388607, -8388608, 1);
    add_pos(100, 0, 500, 0);
    add_pos(100, 0, 500, 1);
    add_pos(0, 200, -300, 0);
    add_pos(0, 300, -300, 1);
    add_pos(-5000, 0, 100000, 0);
    add_pos(-6000, 1, 100000, 0);
    add_pos(7, -7, -8388608, 1);
    drain();

    // Setting phases: extremes and near-default values first, then random register values
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(ael_pkg::RegOriginX, 8388607); cfg_write(ael_pkg::RegOriginY, 8388607);
          cfg_write(ael_pkg::RegOriginZ, 8388607);
          cfg_write(ael_pkg::RegProjRad, 24'hFFFFFF);
          cfg_write(ael_pkg::RegBoxW, 0); cfg_write(ael_pkg::RegBoxH, 0);
          cfg_write(ael_pkg::RegMirX, 1); cfg_write(ael_pkg::RegMirY, 1);
        end
        1: begin
          cfg_write(ael_pkg::RegOriginX, -8388608);
          cfg_write(ael_pkg::RegOriginY, -8388608);
          cfg_write(ael_pkg::RegOriginZ, -8388608); cfg_write(ael_pkg::RegProjRad, 0);
          cfg_write(ael_pkg::RegBoxW, 24'hFFFFFF); cfg_write(ael_pkg::RegBoxH, 24'hFFFFFF);
          cfg_write(ael_pkg::RegMirX, 0); cfg_write(ael_pkg::RegMirY, 1);
        end
        2: begin
          cfg_write(ael_pkg::RegOriginX, 0); cfg_write(ael_pkg::RegOriginY, 0);
          cfg_write(ael_pkg::RegOriginZ, 0);
          cfg_write(ael_pkg::RegProjRad, ael_pkg::ProjRadRst);
          cfg_write(ael_pkg::RegBoxW, ael_pkg::BoxRst); cfg_write(ael_pkg::RegBoxH, 1);
          cfg_write(ael_pkg::RegMirX, 1); cfg_write(ael_pkg::RegMirY, 0);
        end
        default: begin
          for (int r = 0; r < 8; r++)
            if ($urandom_range(0, 3) != 0)
              cfg_write(r[ael_pkg::CfgAw-1:0], longint'($urandom));
        end
      endcase
      phase_items = pos_queue.size();
      while (pos_queue.size() - phase_items < 76) random_set();
      // occasionally leave a set open across the next setting change
      if (ph % 3 == 1) add_pos($signed(24'($urandom)), $signed(24'($urandom)),
                               $signed(24'($urandom)), 0);
      drain();
    end

    $display("covered %0d point sets across 8 register settings, %0d results checked",
             sets_sent, results_seen);
    $display("%0d degenerate sets flagged, %0d mismatches", degen_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: azimuthal_equidistant_layout.f
rtl/core/ael_pkg.sv
rtl/core/azimuthal_equidistant_layout.sv
tb/sv/tb.sv
